@@ sv/lru_lookup_cache_top_defines.svh @@
// Assertion macros for the LRU lookup cache.
// Used by modules that assert; they expect clk and arst_n in scope.
`ifndef LRU_LOOKUP_CACHE_TOP_DEFINES_SVH
`define LRU_LOOKUP_CACHE_TOP_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define LRU_ASSERT_IMPLY(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("lru cache assertion failed");

// Next-cycle implication, disabled during reset.
`define LRU_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("lru cache assertion failed");

`endif

@@ sv/lru_pkg.sv @@
// Shared constants and types for the LRU lookup cache.
// No dependencies; used by lru_cell and lru_lookup_cache_top.
package lru_pkg;

	localparam int ENTRIES  = 4;
	localparam int KEY_BITS = 16;

	localparam int KEY_W    = 16;
	localparam int VALUE_W  = 32;
	localparam int IN_W     = 48;
	localparam int OUT_W    = 8;
	localparam int CMP_BITS = (KEY_BITS < KEY_W) ? KEY_BITS : KEY_W;
	localparam int AGE_W    = (ENTRIES > 2) ? $clog2(ENTRIES) : 1;
	localparam logic [AGE_W-1:0] AGE_MAX = AGE_W'(ENTRIES - 1);

	// Request broadcast to every cell.
	typedef struct packed {
		logic                      en;
		logic [CMP_BITS-1:0]       key;
		logic signed [VALUE_W-1:0] value;
	} req_t;

	// Lookup outcome broadcast back to every cell.
	typedef struct packed {
		logic             hit;
		logic [AGE_W-1:0] hit_age;
	} bcast_t;

	// Per-cell status toward the top level.
	typedef struct packed {
		logic             match;
		logic             valid;
		logic             victim;
		logic [AGE_W-1:0] age;
	} cell_stat_t;

endpackage

@@ sv/lru_cell.sv @@
// One cache entry: key, value, valid bit and LRU age rank.
// Depends on lru_pkg; chained to its neighbor by the valid bit.
module lru_cell (
	input  logic                clk,
	input  logic                arst_n,
	input  lru_pkg::req_t       req,
	input  lru_pkg::bcast_t     bcast,
	input  logic                prev_valid,
	output lru_pkg::cell_stat_t stat
);
	import lru_pkg::*;

	logic [CMP_BITS-1:0]       key_q;
	logic signed [VALUE_W-1:0] value_q;
	logic                      valid_q;
	logic [AGE_W-1:0]          age_q;
	logic                      free_here;
	logic                      wr;

	// Entries fill from index 0 up and are never dropped, so the first
	// empty slot is the one whose lower neighbor is valid.
	assign free_here   = !valid_q && prev_valid;
	assign stat.match  = valid_q && (key_q == req.key);
	assign stat.valid  = valid_q;
	assign stat.victim = valid_q && (age_q == AGE_MAX);
	assign stat.age    = age_q;
	assign wr          = req.en && !bcast.hit && (free_here || stat.victim);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			age_q   <= '0;
		end else if (req.en) begin
			if (bcast.hit) begin
				if (stat.match) begin
					age_q <= '0;
				end else if (valid_q && (age_q < bcast.hit_age)) begin
					age_q <= age_q + 1'b1;
				end
			end else if (wr) begin
				valid_q <= 1'b1;
				age_q   <= '0;
			end else if (valid_q && (age_q != AGE_MAX)) begin
				age_q <= age_q + 1'b1;
			end
		end
	end

	// Payload: write on a fill, no reset.
	always_ff @(posedge clk) begin
		if (wr) begin
			key_q   <= req.key;
			value_q <= req.value;
		end
	end

endmodule

@@ sv/lru_lookup_cache_top.sv @@
// Top level of the fully associative LRU lookup cache.
// Depends on lru_pkg, lru_cell and lru_lookup_cache_top_defines.svh.
//
// Channel   Dir  Handshake            Payload (low bit up)
// -------   ---  -------------------  -----------------------------------
// s_*       in   s_tvalid / s_tready  s_tdata: key[15:0], fill_value[47:16]
// m_*       out  m_tvalid / m_tready  m_tdata: hit[0], zero pad [7:1]
//
// One request per cycle unless m_* stalls: every cell compares its key with the
// request in parallel and updates its rank at the edge of the transfer; the hit flag is
// written to the output register at that same edge and shows on m_* the next cycle.
// Reset clears all valid bits and ranks at once; no clearing pass.
// A new request is taken while the output register is empty or drains in
// the same cycle; a stalled output holds the input side.
`include "lru_lookup_cache_top_defines.svh"

module lru_lookup_cache_top (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      s_tvalid,
	output logic                      s_tready,
	input  logic [lru_pkg::IN_W-1:0]  s_tdata,  // key[15:0], fill_value[47:16]
	output logic                      m_tvalid,
	input  logic                      m_tready,
	output logic [lru_pkg::OUT_W-1:0] m_tdata   // hit[0], zeros[7:1]
);
	import lru_pkg::*;

	req_t             req;
	bcast_t           bcast;
	cell_stat_t       stat [ENTRIES];
	logic [ENTRIES-1:0] match_vec;
	logic [ENTRIES-1:0] valid_vec;
	logic [ENTRIES-1:0] victim_vec;
	logic [ENTRIES-1:0] valid_inc;
	logic [AGE_W-1:0] hit_age;
	logic             m_tvalid_q;
	logic             hit_q;
	logic             fill_room;

	// Accept whenever the output register is free or is being emptied.
	assign s_tready  = !m_tvalid_q || m_tready;
	assign req.en    = s_tvalid && s_tready;
	assign req.key   = s_tdata[CMP_BITS-1:0];
	assign req.value = $signed(s_tdata[KEY_W +: VALUE_W]);

	// Gather cell status; at most one cell matches, so an OR picks its age.
	always_comb begin
		hit_age = '0;
		for (int i = 0; i < ENTRIES; i++) begin
			match_vec[i]  = stat[i].match;
			valid_vec[i]  = stat[i].valid;
			victim_vec[i] = stat[i].victim;
			hit_age       = hit_age | (stat[i].match ? stat[i].age : '0);
		end
	end

	assign bcast.hit     = |match_vec;
	assign bcast.hit_age = hit_age;

	// Row of cells; each passes its valid bit up to the next.
	for (genvar g = 0; g < ENTRIES; g++) begin : g_cell
		logic prev_valid;
		if (g == 0) begin : g_first
			assign prev_valid = 1'b1;
		end else begin : g_rest
			assign prev_valid = valid_vec[g-1];
		end
		lru_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.req        (req),
			.bcast      (bcast),
			.prev_valid (prev_valid),
			.stat       (stat[g])
		);
	end

	// Output register: hold while the sink stalls.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (s_tready) begin
			m_tvalid_q <= req.en;
		end
	end

	always_ff @(posedge clk) begin
		if (req.en) begin
			hit_q <= bcast.hit;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {(OUT_W-1)'(0), hit_q};

	// Valid entries always form a run from index 0.
	assign valid_inc = valid_vec + 1'b1;

	// A miss while a slot is still empty extends the valid run by one.
	assign fill_room = req.en && !bcast.hit && !(&valid_vec);

	`LRU_ASSERT_IMPLY(a_single_match, 1'b1, $onehot0(match_vec))
	`LRU_ASSERT_IMPLY(a_one_victim_when_full, &valid_vec, $onehot(victim_vec))
	`LRU_ASSERT_IMPLY(a_valid_prefix, 1'b1, (valid_inc & valid_vec) == '0)
	`LRU_ASSERT_NEXT(a_miss_fills, fill_room, valid_vec == {$past(valid_vec[ENTRIES-2:0]), 1'b1})

endmodule

@@ tb/testbench.sv @@
// Testbench for lru_lookup_cache_top: random streaming traffic checked against an LRU model.
// Depends on lru_pkg and the RTL of lru_lookup_cache_top; reads no files.
`timescale 1ns / 100ps

// Holds a private copy of the cache tags, ranks and valid bits.
// Predicts the hit flag for every accepted request and checks results in order.
class lru_hit_scoreboard;
	bit [lru_pkg::CMP_BITS-1:0]      tag_mem[lru_pkg::ENTRIES];
	bit signed [lru_pkg::VALUE_W-1:0] data_mem[lru_pkg::ENTRIES];
	bit                              used[lru_pkg::ENTRIES];
	bit [lru_pkg::AGE_W-1:0]         rank[lru_pkg::ENTRIES];
	bit                              expected_hits[$];
	int                              mismatches;
	int                              results_seen;

	function new();
		mismatches   = 0;
		results_seen = 0;
		for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
			used[i] = 1'b0;
			rank[i] = '0;
		end
	endfunction

	// Saturate at the oldest rank.
	function void age_entry(int i);
		if (rank[i] != lru_pkg::AGE_MAX)
			rank[i]++;
	endfunction

	function bit predict_hit(bit [lru_pkg::KEY_W-1:0] key, bit signed [lru_pkg::VALUE_W-1:0] fill);
		bit [lru_pkg::CMP_BITS-1:0] tag;
		bit [lru_pkg::AGE_W-1:0]    hit_rank;
		bit [lru_pkg::AGE_W-1:0]    oldest;
		int                         slot;
		tag  = key[lru_pkg::CMP_BITS-1:0];
		slot = -1;
		for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
			if (slot < 0 && used[i] && tag_mem[i] == tag)
				slot = i;
		end
		if (slot >= 0) begin
			// Hit: age only the valid entries younger than the hit one.
			hit_rank = rank[slot];
			for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
				if (i != slot && used[i] && rank[i] < hit_rank)
					age_entry(i);
			end
			rank[slot] = '0;
			return 1'b1;
		end
		// Miss: take the lowest free slot, else the oldest (lowest index on a tie).
		for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
			if (slot < 0 && !used[i])
				slot = i;
		end
		if (slot < 0) begin
			oldest = '0;
			slot   = 0;
			for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
				if (rank[i] > oldest) begin
					oldest = rank[i];
					slot   = i;
				end
			end
		end
		for (int i = 0; i < lru_pkg::ENTRIES; i++) begin
			if (i != slot && used[i])
				age_entry(i);
		end
		tag_mem[slot]  = tag;
		data_mem[slot] = fill;
		used[slot]     = 1'b1;
		rank[slot]     = '0;
		return 1'b0;
	endfunction

	function void note_request(bit [lru_pkg::KEY_W-1:0] key, bit signed [lru_pkg::VALUE_W-1:0] fill);
		expected_hits.push_back(predict_hit(key, fill));
	endfunction

	function void check_response(logic [lru_pkg::OUT_W-1:0] tdata);
		logic [lru_pkg::OUT_W-1:0] want;
		results_seen++;
		if (expected_hits.size() == 0) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d arrived with nothing expected: tdata %h", results_seen, tdata);
			return;
		end
		// Pad bits above hit must read as zero.
		want = lru_pkg::OUT_W'(expected_hits.pop_front());
		if (tdata !== want) begin
			mismatches++;
			if (mismatches <= 10)
				$display("result %0d hit mismatch: expected tdata %h, got %h",
					results_seen, want, tdata);
		end
	endfunction

	function int pending();
		return expected_hits.size();
	endfunction
endclass

module testbench;
	import lru_pkg::*;

	localparam int CYCLE_LIMIT  = 250000;
	localparam int RANDOM_ITEMS = 1350;
	localparam int MAX_GAP      = 13;

	logic                clk      = 1'b0;
	logic                arst_n   = 1'b0;
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [IN_W-1:0]     s_tdata  = '0;  // key[15:0], fill_value[47:16]
	logic                m_tvalid;
	logic                m_tready = 1'b0;
	logic [OUT_W-1:0]    m_tdata;         // hit[0], zeros[7:1]

	lru_hit_scoreboard   sb;
	int unsigned         cycle_count = 0;
	bit                  sender_burst = 1'b0;

	lru_lookup_cache_top DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// 12 ns clock.
	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	// Watchdog: fail the run if it stalls far beyond the slowest correct run.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("CHECKS FAILED");
		$finish;
	end

	function automatic int draw_gap(bit burst);
		return burst ? 0 : $urandom_range(0, MAX_GAP);
	endfunction

	// Present one request after a random idle gap, if any, and hold it until the transfer.
	// Keep tvalid high across back-to-back requests.
	task automatic send_request(input bit [KEY_W-1:0] key, input bit signed [VALUE_W-1:0] fill);
		int gap;
		gap = draw_gap(sender_burst);
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= {fill, key};
		do
			@(posedge clk);
		while (!s_tready);
		sb.note_request(key, fill);
	endtask

	// Stall the result side at random; redraw the stall mode every 64 results.
	task automatic drain_results();
		int  stall;
		int  taken;
		bit  burst;
		taken = 0;
		burst = 1'b0;
		forever begin
			if (taken % 64 == 0)
				burst = ($urandom_range(0, 3) == 0);
			stall = draw_gap(burst);
			if (stall > 0) begin
				m_tready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!m_tvalid);
			sb.check_response(m_tdata);
			taken++;
		end
	endtask

	initial begin
		bit [KEY_W-1:0]          directed_keys[16];
		bit signed [VALUE_W-1:0] directed_fills[16];
		bit [KEY_W-1:0]          key_pool[8];
		bit signed [VALUE_W-1:0] fill;
		bit [KEY_W-1:0]          key;
		int                      pool_size;
		int                      phase_len;
		int                      sent;

		sb = new();

		// Hold reset from time zero; release at a clock edge.
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		fork
			drain_results();
		join_none

		// Directed: fill the empty cache, hit the youngest and the oldest entry,
		// evict when full, hit repeatedly, and probe keys one bit away from stored ones.
		directed_keys = '{16'h0000, 16'h0000, 16'hFFFF, 16'h5AA5,
		                  16'hA55A, 16'h0000, 16'hA55A, 16'h0001,
		                  16'hFFFF, 16'h0000, 16'h8000, 16'h8000,
		                  16'h8000, 16'h7FFF, 16'h0001, 16'hA55A};
		directed_fills = '{32'sh8000_0000, 32'sh1234_5678, 32'sh7FFF_FFFF, 32'sh0000_0000,
		                   -32'sd1, 32'sh0F0F_0F0F, 32'shF0F0_F0F0, 32'sh0000_0001,
		                   32'sh8000_0000, 32'sh7FFF_FFFF, 32'shAAAA_AAAA, 32'sh5555_5555,
		                   32'sh0000_0000, -32'sd1, 32'sh8000_0001, 32'sh7FFF_FFFE};
		for (int i = 0; i < 16; i++)
			send_request(directed_keys[i], directed_fills[i]);

		// Random phases: draw a key pool per phase; a pool no larger than the cache
		// mostly hits, a larger one forces steady eviction. Mix in stray keys.
		sent = 0;
		while (sent < RANDOM_ITEMS) begin
			pool_size    = $urandom_range(2, 8);
			phase_len    = $urandom_range(40, 160);
			sender_burst = ($urandom_range(0, 3) == 0);
			for (int i = 0; i < 8; i++)
				key_pool[i] = KEY_W'($urandom);
			for (int i = 0; i < phase_len && sent < RANDOM_ITEMS; i++) begin
				if ($urandom_range(0, 99) < 85)
					key = key_pool[$urandom_range(0, pool_size - 1)];
				else
					key = KEY_W'($urandom);
				fill = VALUE_W'($urandom);
				send_request(key, fill);
				sent++;
			end
		end

		// Drop tvalid once the last request has transferred.
		s_tvalid <= 1'b0;

		while (sb.pending() != 0)
			@(posedge clk);
		// Allow for any stray extra result.
		repeat (8) @(posedge clk);

		if (sb.mismatches == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
